// ----- hw/rtl/dsf_pkg.sv -----
// ---------------------------------------------------------------------------
// dsf_pkg
// Types, constants and stage map shared by the damped spring force block.
// ---------------------------------------------------------------------------
package dsf_pkg;

   localparam int FIFO_DEPTH_DEF = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 31;
   localparam logic [30:0] REST_RESET = 31'd65536;
   localparam logic [65:0] LEN_MIN_SQ = 66'd429497;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REST  = 2'd0,
      CSR_STIFF = 2'd1,
      CSR_DAMP  = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic signed [31:0] end1_x;
      logic signed [31:0] end1_y;
      logic signed [31:0] end2_x;
      logic signed [31:0] end2_y;
      logic signed [31:0] end1_vel_x;
      logic signed [31:0] end1_vel_y;
      logic signed [31:0] end2_vel_x;
      logic signed [31:0] end2_vel_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic [30:0]        spring_length;
      logic [30:0]        spring_energy;
   } rsp_type;

   // classified item passed from front to back
   typedef struct packed {
      logic               sgx;
      logic               sgy;
      logic [32:0]        ax;
      logic [32:0]        ay;
      logic signed [32:0] rvx;
      logic signed [32:0] rvy;
   } fr_type;

   localparam int FR_W = $bits(fr_type);

   typedef struct packed {
      logic               sgx;
      logic               sgy;
      logic [32:0]        ax;
      logic [32:0]        ay;
      logic signed [32:0] rvx;
      logic signed [32:0] rvy;
      logic [64:0]        sqx;
      logic [64:0]        sqy;
      logic [65:0]        s;
      logic               short_len;
      logic [32:0]        root;
      logic [34:0]        rem;
      logic signed [33:0] x;
      logic [32:0]        xm;
      logic [61:0]        numx;
      logic [61:0]        numy;
      logic [33:0]        remx;
      logic [33:0]        remy;
      logic [28:0]        ux;
      logic [28:0]        uy;
      logic [61:0]        prodx;
      logic [61:0]        prody;
      logic [63:0]        dpx;
      logic [63:0]        dpy;
      logic [63:0]        esq;
      logic [33:0]        px;
      logic [33:0]        py;
      logic [48:0]        dmx;
      logic [48:0]        dmy;
      logic [47:0]        q;
      logic [48:0]        spx;
      logic [48:0]        spy;
      logic [62:0]        elo;
      logic [46:0]        ehi;
      rsp_type            rsp;
   } bk_type;

   // back pipeline stage map
   localparam int ST_SQ   = 0;
   localparam int ST_SUM  = 1;
   localparam int ST_RT0  = 2;
   localparam int ST_RTN  = 34;
   localparam int ST_LEN  = 35;
   localparam int ST_DV0  = 36;
   localparam int ST_DVN  = 64;
   localparam int ST_MUL  = 65;
   localparam int ST_RND  = 66;
   localparam int ST_KS   = 67;
   localparam int ST_OUT  = 68;
   localparam int NSTG    = 69;

endpackage

// ----- hw/rtl/dsf_front.sv -----
// ---------------------------------------------------------------------------
// dsf_front
// Input stage: takes a beat, forms end differences, magnitudes and signs.
// ---------------------------------------------------------------------------
module dsf_front
   import dsf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    out_valid,
   input  logic    out_ready,
   output fr_type  out_data
);

   logic   valid_ff, valid_in;
   fr_type data_ff, data_in;
   logic signed [32:0] dx, dy;

   assign req_ready = !valid_ff || out_ready;

   always_comb begin
      dx = 33'(req_data.end2_x) - 33'(req_data.end1_x);
      dy = 33'(req_data.end2_y) - 33'(req_data.end1_y);
      data_in.sgx = dx[32];
      data_in.sgy = dy[32];
      data_in.ax  = dx[32] ? 33'(-dx) : 33'(dx);
      data_in.ay  = dy[32] ? 33'(-dy) : 33'(dy);
      data_in.rvx = 33'(req_data.end2_vel_x) - 33'(req_data.end1_vel_x);
      data_in.rvy = 33'(req_data.end2_vel_y) - 33'(req_data.end1_vel_y);
      valid_in = req_valid || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- hw/rtl/dsf_fifo.sv -----
// ---------------------------------------------------------------------------
// dsf_fifo
// Short register queue between the front and back parts.
// ---------------------------------------------------------------------------
module dsf_fifo
   import dsf_pkg::*;
#(
   parameter int DEPTH = FIFO_DEPTH_DEF,
   parameter int WIDTH = FR_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             push, pop;

   assign push_ready = cnt_ff != CNT_FULL;
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = mem_ff[rd_ff];
   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   always_comb begin
      wr_in  = push ? ((wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? ((rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL) else $error("queue count overflow");
   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + CW'(1))
      else $error("queue count lost a push");

endmodule

// ----- hw/rtl/dsf_back.sv -----
// ---------------------------------------------------------------------------
// dsf_back
// Execution pipeline: squares, staged square root, staged divides for the
// unit vector, gain multiplies, rounding and saturation.
// ---------------------------------------------------------------------------
module dsf_back
   import dsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [30:0] rest_length,
   input  logic [30:0] stiffness,
   input  logic [30:0] damping,
   input  logic        in_valid,
   output logic        in_ready,
   input  fr_type      in_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   bk_type pipe_ff [NSTG];
   bk_type pipe_in [NSTG];
   bk_type src     [NSTG];
   logic [NSTG-1:0] vld_ff;
   logic en;

   assign en = !vld_ff[ST_OUT] || rsp_ready;
   assign in_ready = en;

   always_comb begin
      src[0] = '0;
      src[0].sgx = in_data.sgx;
      src[0].sgy = in_data.sgy;
      src[0].ax  = in_data.ax;
      src[0].ay  = in_data.ay;
      src[0].rvx = in_data.rvx;
      src[0].rvy = in_data.rvy;
   end

   for (genvar g = 1; g < NSTG; g++) begin : g_src
      assign src[g] = pipe_ff[g-1];
   end

   always_comb begin
      bk_type c;
      logic [35:0] r36, tr;
      logic [34:0] rx, ry;
      logic [32:0] rvm_x, rvm_y;
      logic [50:0] sgn_sp, sgn_dm;
      logic [51:0] sum;
      logic [62:0] e;
      r36    = '0;
      tr     = '0;
      rx     = '0;
      ry     = '0;
      rvm_x  = '0;
      rvm_y  = '0;
      sgn_sp = '0;
      sgn_dm = '0;
      sum    = '0;
      e      = '0;
      for (int i = 0; i < NSTG; i++) begin
         c = src[i];
         if (i == ST_SQ) begin
            c.sqx = {32'd0, c.ax} * {32'd0, c.ax};
            c.sqy = {32'd0, c.ay} * {32'd0, c.ay};
         end else if (i == ST_SUM) begin
            c.s = {1'b0, c.sqx} + {1'b0, c.sqy};
            c.short_len = c.s < LEN_MIN_SQ;
            c.root = '0;
            c.rem  = '0;
         end else if (i >= ST_RT0 && i <= ST_RTN) begin
            r36 = {c.rem[33:0], c.s[2*(ST_RTN-i) +: 2]};
            tr  = {1'b0, c.root, 2'b01};
            if (r36 >= tr) begin
               c.rem  = 35'(r36 - tr);
               c.root = {c.root[31:0], 1'b1};
            end else begin
               c.rem  = r36[34:0];
               c.root = {c.root[31:0], 1'b0};
            end
         end else if (i == ST_LEN) begin
            c.x    = $signed({1'b0, c.root}) - $signed({3'b0, rest_length});
            c.xm   = c.x[33] ? 33'(-c.x) : 33'(c.x);
            c.numx = {1'b0, c.ax, 28'd0} + {29'd0, c.root[32:1]};
            c.numy = {1'b0, c.ay, 28'd0} + {29'd0, c.root[32:1]};
            c.remx = {1'b0, c.numx[61:29]};
            c.remy = {1'b0, c.numy[61:29]};
            c.ux   = '0;
            c.uy   = '0;
         end else if (i >= ST_DV0 && i <= ST_DVN) begin
            rx = {c.remx, c.numx[ST_DVN-i]};
            ry = {c.remy, c.numy[ST_DVN-i]};
            if (rx >= {2'b0, c.root}) begin
               c.remx = 34'(rx - {2'b0, c.root});
               c.ux   = {c.ux[27:0], 1'b1};
            end else begin
               c.remx = rx[33:0];
               c.ux   = {c.ux[27:0], 1'b0};
            end
            if (ry >= {2'b0, c.root}) begin
               c.remy = 34'(ry - {2'b0, c.root});
               c.uy   = {c.uy[27:0], 1'b1};
            end else begin
               c.remy = ry[33:0];
               c.uy   = {c.uy[27:0], 1'b0};
            end
         end else if (i == ST_MUL) begin
            rvm_x   = c.rvx[32] ? 33'(-c.rvx) : 33'(c.rvx);
            rvm_y   = c.rvy[32] ? 33'(-c.rvy) : 33'(c.rvy);
            c.prodx = {33'd0, c.ux} * {29'd0, c.xm};
            c.prody = {33'd0, c.uy} * {29'd0, c.xm};
            c.dpx   = {31'd0, rvm_x} * {33'd0, damping};
            c.dpy   = {31'd0, rvm_y} * {33'd0, damping};
            c.esq   = {32'd0, c.xm[31:0]} * {32'd0, c.xm[31:0]};
         end else if (i == ST_RND) begin
            c.px  = 34'(({1'b0, c.prodx} + 63'(1 << 27)) >> 28);
            c.py  = 34'(({1'b0, c.prody} + 63'(1 << 27)) >> 28);
            c.dmx = 49'(({1'b0, c.dpx} + 65'(1 << 15)) >> 16);
            c.dmy = 49'(({1'b0, c.dpy} + 65'(1 << 15)) >> 16);
            c.q   = c.xm[32] ? '1 : 48'(({1'b0, c.esq} + 65'(1 << 15)) >> 16);
         end else if (i == ST_KS) begin
            c.spx = 49'(({1'b0, {31'd0, c.px} * {34'd0, stiffness}} + 66'(1 << 15)) >> 16);
            c.spy = 49'(({1'b0, {31'd0, c.py} * {34'd0, stiffness}} + 66'(1 << 15)) >> 16);
            c.elo = {31'd0, c.q[31:0]} * {32'd0, stiffness};
            c.ehi = {31'd0, c.q[47:32]} * {16'd0, stiffness};
         end else if (i == ST_OUT) begin
            if (c.short_len) begin
               sgn_sp = '0;
            end else if (c.sgx != c.x[33]) begin
               sgn_sp = 51'(-{2'b0, c.spx});
            end else begin
               sgn_sp = {2'b0, c.spx};
            end
            sgn_dm = c.rvx[32] ? 51'(-{2'b0, c.dmx}) : {2'b0, c.dmx};
            sum = 52'($signed(sgn_sp)) + 52'($signed(sgn_dm));
            if (!sum[51] && sum[50:31] != '0) begin
               c.rsp.force_x = 32'sh7FFFFFFF;
            end else if (sum[51] && sum[50:31] != '1) begin
               c.rsp.force_x = 32'sh80000000;
            end else begin
               c.rsp.force_x = sum[31:0];
            end
            if (c.short_len) begin
               sgn_sp = '0;
            end else if (c.sgy != c.x[33]) begin
               sgn_sp = 51'(-{2'b0, c.spy});
            end else begin
               sgn_sp = {2'b0, c.spy};
            end
            sgn_dm = c.rvy[32] ? 51'(-{2'b0, c.dmy}) : {2'b0, c.dmy};
            sum = 52'($signed(sgn_sp)) + 52'($signed(sgn_dm));
            if (!sum[51] && sum[50:31] != '0) begin
               c.rsp.force_y = 32'sh7FFFFFFF;
            end else if (sum[51] && sum[50:31] != '1) begin
               c.rsp.force_y = 32'sh80000000;
            end else begin
               c.rsp.force_y = sum[31:0];
            end
            c.rsp.spring_length = (c.root[32:31] != '0) ? '1 : c.root[30:0];
            e = {1'b0, c.ehi, 15'd0} + 63'(({1'b0, c.elo} + 64'(1 << 16)) >> 17);
            c.rsp.spring_energy = (e[62:31] != '0) ? '1 : e[30:0];
         end
         pipe_in[i] = c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid};
      end
      if (en) begin
         for (int i = 0; i < NSTG; i++) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   assign rsp_valid = vld_ff[ST_OUT];
   assign rsp_data  = pipe_ff[ST_OUT].rsp;

   a_root_low: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_RTN] |-> ({33'd0, pipe_ff[ST_RTN].root} * {33'd0, pipe_ff[ST_RTN].root})
         <= pipe_ff[ST_RTN].s) else $error("square root too large");
   a_root_high: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_RTN] |-> ({34'd0, pipe_ff[ST_RTN].root} + 67'd1) *
         ({34'd0, pipe_ff[ST_RTN].root} + 67'd1) > {1'b0, pipe_ff[ST_RTN].s})
      else $error("square root too small");
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_DVN] && !pipe_ff[ST_DVN].short_len |->
         pipe_ff[ST_DVN].ux <= 29'(1 << 28) && pipe_ff[ST_DVN].uy <= 29'(1 << 28))
      else $error("unit vector component above one");

endmodule

// ----- hw/rtl/damped_spring_force_2d.sv -----
// ---------------------------------------------------------------------------
// damped_spring_force_2d
// Damped 2D spring force on signed Q16.16 end positions and velocities.
// ---------------------------------------------------------------------------
// Fully pipelined: one beat is accepted per cycle unless rsp_ready holds off
// and backs the pipeline up. A result passes one front stage, the queue and
// 69 back stages, set by the 33-step square root and 29-step unit-vector
// divide, one stage per step. The user writes registers through the csr_ port
// only while no beat is in flight; the block does not enforce this.
module damped_spring_force_2d
   import dsf_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [30:0] rest_ff, stiff_ff, damp_ff;
   logic        f_valid, f_ready, q_valid, q_ready;
   fr_type      f_data, q_data;
   logic [FR_W-1:0] q_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff  <= REST_RESET;
         stiff_ff <= '0;
         damp_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_REST:  rest_ff  <= csr_wdata;
            CSR_STIFF: stiff_ff <= csr_wdata;
            CSR_DAMP:  damp_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   dsf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   dsf_fifo #(
      .DEPTH (FIFO_DEPTH),
      .WIDTH (FR_W)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_raw)
   );

   assign q_data = fr_type'(q_raw);

   dsf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .rest_length (rest_ff),
      .stiffness   (stiff_ff),
      .damping     (damp_ff),
      .in_valid    (q_valid),
      .in_ready    (q_ready),
      .in_data     (q_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- tb/sv/tb_damped_spring_force_2d.sv -----
// ---------------------------------------------------------------------------
// tb_damped_spring_force_2d
// Drives spring beats through the force block and checks every result
// against a bit-true predictor of the fixed-point spring and damper math
// or a typed value. A directed table of corner cases and random beats is run
// under several register settings, with random idling on both channels and
// one long receiver hold-off that backs the pipeline up.
// ---------------------------------------------------------------------------
module tb_damped_spring_force_2d;
   import dsf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int NPHASE    = 7;
   localparam int NRAND     = 190;
   localparam int DRAIN     = 100;
   localparam int HOLD_OFF  = 400;
   localparam int WDOG_MAX  = 3000;
   localparam logic [30:0] MAX31 = 31'h7fffffff;

   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type want;
   } row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   logic [30:0] rest_len, k_stiff, k_damp;
   rsp_type     force_due[$];
   row_type     corner_rows[$];
   int          mismatches;
   int          idle_cycles;
   bit          quiet;
   bit          hold_req;

   damped_spring_force_2d dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [127:0] rnd_mul(logic [127:0] m, logic [127:0] k, int sh);
      return (m * k + (128'd1 << (sh - 1))) >> sh;
   endfunction

   function automatic logic [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic longint axis_force(longint d, logic [33:0] l, bit dir_ok, longint x,
                                         longint relv);
      logic [127:0] u, p, s, dm;
      longint spring;
      spring = 0;
      if (dir_ok) begin
         u = ((128'(mag(d)) << 28) + (l >> 1)) / l;
         p = (u * mag(x) + (128'd1 << 27)) >> 28;
         s = rnd_mul(p, k_stiff, 16);
         spring = ((d < 0) != (x < 0)) ? -longint'(s[63:0]) : longint'(s[63:0]);
      end
      dm = rnd_mul(mag(relv), k_damp, 16);
      return spring + (relv < 0 ? -longint'(dm[63:0]) : longint'(dm[63:0]));
   endfunction

   function automatic rsp_type spring_force(req_type r);
      longint dx, dy, rvx, rvy, x;
      logic [32:0] ax, ay;
      logic [65:0] sq;
      logic [35:0] rem, trial;
      logic [33:0] root;
      logic [63:0] xm;
      logic [127:0] q, e;
      bit dir_ok;
      rsp_type o;
      dx = longint'(r.end2_x) - longint'(r.end1_x);
      dy = longint'(r.end2_y) - longint'(r.end1_y);
      rvx = longint'(r.end2_vel_x) - longint'(r.end1_vel_x);
      rvy = longint'(r.end2_vel_y) - longint'(r.end1_vel_y);
      ax = 33'(mag(dx));
      ay = 33'(mag(dy));
      sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
      rem = '0;
      root = '0;
      for (int i = 32; i >= 0; i--) begin
         rem = {rem[33:0], sq[2*i+1 -: 2]};
         trial = {root, 2'b01};
         if (rem >= trial) begin
            rem = rem - trial;
            root = {root[32:0], 1'b1};
         end else begin
            root = {root[32:0], 1'b0};
         end
      end
      dir_ok = (sq >= LEN_MIN_SQ) && (root != 0);
      x = longint'(root) - longint'(rest_len);
      xm = mag(x);
      o.force_x = sat32(axis_force(dx, root, dir_ok, x, rvx));
      o.force_y = sat32(axis_force(dy, root, dir_ok, x, rvy));
      o.spring_length = (root > MAX31) ? MAX31 : root[30:0];
      if (xm >= 64'h1_0000_0000) q = (128'd1 << 48) - 1;
      else q = (128'(xm) * xm + (128'd1 << 15)) >> 16;
      e = rnd_mul(q, k_stiff, 17);
      o.spring_energy = (e > MAX31) ? MAX31 : e[30:0];
      return o;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      mismatches++;
   endtask

   // accepted beats on both sides
   always @(posedge clock) begin
      rsp_type w;
      if (!reset) begin
         if (req_valid && req_ready) idle_cycles <= 0;
         else if (rsp_valid && rsp_ready) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (force_due.size() == 0) begin
               report("unexpected result beat", rsp_data.force_x, 0);
            end else begin
               w = force_due.pop_front();
               if (rsp_data.force_x !== w.force_x) report("force_x", rsp_data.force_x, w.force_x);
               if (rsp_data.force_y !== w.force_y) report("force_y", rsp_data.force_y, w.force_y);
               if (rsp_data.spring_length !== w.spring_length)
                  report("spring_length", rsp_data.spring_length, w.spring_length);
               if (rsp_data.spring_energy !== w.spring_energy)
                  report("spring_energy", rsp_data.spring_energy, w.spring_energy);
            end
         end
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (idle_cycles >= WDOG_MAX) begin
            $display("[damped_spring_force_2d] ERROR");
            $finish;
         end
      end
   end

   // receiver
   initial begin
      rsp_ready = 1'b0;
      hold_req = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
            hold_req = 1'b0;
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= 16);
         end
      end
   end

   task automatic send(req_type r, bit typed, rsp_type want);
      if (!quiet && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      force_due.push_back(typed ? want : spring_force(r));
   endtask

   // leaves the write enable high; the caller drops it after the last write
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [30:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_REST:  rest_len = val;
         CSR_STIFF: k_stiff = val;
         CSR_DAMP:  k_damp = val;
         default: ;
      endcase
   endtask

   function automatic logic [31:0] rand_val(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(2097152)) - 1048576);
         2: return 32'($signed($urandom_range(1400)) - 700);
         default: return 32'($signed($urandom_range(33554432)) - 16777216);
      endcase
   endfunction

   function automatic req_type rand_beat();
      req_type r;
      int pm, vm;
      pm = $urandom_range(3);
      vm = $urandom_range(3);
      r.end1_x = rand_val(pm == 2 ? 3 : pm);
      r.end1_y = rand_val(pm == 2 ? 3 : pm);
      r.end2_x = (pm == 2) ? r.end1_x + rand_val(2) : rand_val(pm);
      r.end2_y = (pm == 2) ? r.end1_y + rand_val(2) : rand_val(pm);
      if ($urandom_range(19) == 0) begin
         r.end2_x = r.end1_x;
         r.end2_y = r.end1_y;
      end
      r.end1_vel_x = rand_val(vm);
      r.end1_vel_y = rand_val(vm);
      r.end2_vel_x = rand_val(vm);
      r.end2_vel_y = rand_val(vm);
      return r;
   endfunction

   function automatic void add_row(logic [31:0] x1, y1, x2, y2, v1x, v1y, v2x, v2y,
                                   bit typed, logic [31:0] fx, fy, logic [30:0] len, en);
      row_type t;
      t.beat = '{x1, y1, x2, y2, v1x, v1y, v2x, v2y};
      t.typed = typed;
      t.want = '{fx, fy, len, en};
      corner_rows.push_back(t);
   endfunction

   initial begin
      logic [30:0] cfg[NPHASE][3];
      logic [31:0] mn, mx;
      mn = 32'h80000000;
      mx = 32'h7fffffff;
      cfg = '{'{31'd65536, 31'd0, 31'd0},
              '{31'd0, MAX31, MAX31},
              '{MAX31, 31'd1, 31'd0},
              '{31'd131072, 31'd65536, 31'd32768},
              '{31'd65536, 31'd256, 31'd196608},
              '{31'd0, 31'd0, 31'd0},
              '{31'd0, 31'd0, 31'd0}};
      for (int p = 5; p < NPHASE; p++)
         for (int j = 0; j < 3; j++) cfg[p][j] = ($urandom_range(1) ? $urandom : $urandom_range(1 << 20));

      // at reset: rest 1.0, no stiffness, no damping
      add_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
      add_row(0, 0, 196608, 262144, 0, 0, 0, 0, 1, 0, 0, 327680, 0);
      add_row(mn, mn, mx, mx, 0, 0, 0, 0, 1, 0, 0, MAX31, 0);
      add_row(mx, mx, mn, mn, mn, mn, mx, mx, 0, 0, 0, 0, 0);
      add_row(mx, mn, mn, mx, mx, mx, mn, mn, 0, 0, 0, 0, 0);
      add_row(0, 0, 600, 0, 0, 0, 65536, -65536, 0, 0, 0, 0, 0);
      add_row(0, 0, 655, 21, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 655, 22, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, -655, -22, 3, -3, 0, 0, 0, 0, 0, 0, 0);
      add_row(65536, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0);
      add_row(-100000, 50000, 300000, -700000, -1, 1, 5, -5, 0, 0, 0, 0, 0);
      add_row(0, 0, 65536, 0, mn, 0, mx, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 0, -131072, 0, mx, 0, mn, 0, 0, 0, 0, 0);
      add_row(mn, 0, mx, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(-1, -1, 1, 1, -1, -1, 1, 1, 0, 0, 0, 0, 0);

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_REST;
      csr_wdata = '0;
      quiet = 1'b0;
      mismatches = 0;
      rest_len = REST_RESET;
      k_stiff = '0;
      k_damp = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < NPHASE; p++) begin
         if (p > 0) begin
            req_valid <= 1'b0;
            wait (force_due.size() == 0);
            repeat (DRAIN) @(posedge clock);
            csr_write(CSR_REST, cfg[p][0]);
            csr_write(CSR_STIFF, cfg[p][1]);
            csr_write(CSR_DAMP, cfg[p][2]);
            csr_write(CSR_UNUSED, $urandom);
            csr_wr_en <= 1'b0;
         end
         quiet = (p == 2);
         if (p == 3) hold_req = 1'b1;
         foreach (corner_rows[i])
            send(corner_rows[i].beat, p == 0 && corner_rows[i].typed, corner_rows[i].want);
         for (int i = 0; i < NRAND; i++) send(rand_beat(), 1'b0, '0);
      end
      req_valid <= 1'b0;
      wait (force_due.size() == 0);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0) begin
         $display("[damped_spring_force_2d] OK");
      end else begin
         $display("[damped_spring_force_2d] ERROR");
      end
      $finish;
   end

endmodule
